[hw/rtl/pdc_pkg.sv]
// Shared types and constants for the prefix dictionary classifier.
// Used by pdc_cell and prefix_dictionary_classifier_unit; no dependencies.
package pdc_pkg;

    // Widths fixed by the item fields
    localparam int TEXT_W  = 64;
    localparam int SLOT_W  = 6;
    localparam int CFG_W   = 7;
    localparam int KIND_W  = 2;
    localparam int EIDX_W  = 7;
    localparam int LEN_W   = 4;   // name length 0..8

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_INVALID   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PENDING   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_AMBIGUOUS = 2'd3;

    // Exact index when there is no exact hit
    localparam logic [EIDX_W-1:0] EIDX_NONE = 7'h7F;

    // Control traveling with an item from cell to cell
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  tlen;
        logic              exact;
        logic              prefix;
    } t_ctl;

endpackage

[hw/rtl/prefix_dictionary_classifier_unit.sv]
// Prefix dictionary classifier: a chain of TABLE_ENTRIES cells, one per name.
// One item (load or match) per cycle while o_stall is low, set by the chain
// moving items one cell per cycle; a stall halts every cell of the chain.
// Loads travel the chain like matches and write their cell in passing.
// Reset clears the chain valid bits and entries_in_use; names are undefined
// until loaded. Depends on pdc_pkg and pdc_cell.
module prefix_dictionary_classifier_unit
    import pdc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int NAME_CHARS    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_op,
    input  logic [SLOT_W-1:0]        i_entry_slot,
    input  logic [TEXT_W-1:0]        i_text,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [KIND_W-1:0]        o_match_kind,
    output logic signed [EIDX_W-1:0] o_exact_index
);

    localparam int NAME_W = NAME_CHARS * 8;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [CFG_W-1:0]  r_entries_in_use;
    logic              adv;

    logic [NAME_W-1:0] in_tok;
    logic [NAME_W-1:0] in_mask;
    logic [LEN_W-1:0]  in_len;
    logic              live;

    t_ctl              chain_ctl  [TABLE_ENTRIES+1];
    logic [NAME_W-1:0] chain_tok  [TABLE_ENTRIES+1];
    logic [NAME_W-1:0] chain_mask [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  chain_at   [TABLE_ENTRIES+1];

    t_ctl              last_ctl;
    logic [31:0]       at_ext;

    // Hold the entries_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_wdata;
        end
    end

    // Advance the chain unless a result waits on a stalled output
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // Clip the text at its first zero byte and build the prefix mask
    always_comb begin
        in_tok  = '0;
        in_mask = '0;
        in_len  = '0;
        live    = 1'b1;
        for (int b = 0; b < NAME_CHARS; b++) begin
            if (live && (i_text[8*b +: 8] != 8'h00)) begin
                in_tok[8*b +: 8]  = i_text[8*b +: 8];
                in_mask[8*b +: 8] = 8'hFF;
                in_len            = in_len + LEN_W'(1);
            end else begin
                live = 1'b0;
            end
        end
    end

    // Feed the head of the chain
    always_comb begin
        chain_ctl[0].valid  = i_valid;
        chain_ctl[0].op     = i_op;
        chain_ctl[0].slot   = i_entry_slot;
        chain_ctl[0].tlen   = in_len;
        chain_ctl[0].exact  = 1'b0;
        chain_ctl[0].prefix = 1'b0;
    end
    assign chain_tok[0]  = in_tok;
    assign chain_mask[0] = in_mask;
    assign chain_at[0]   = '0;

    // Row of name cells
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        pdc_cell #(
            .CELL_INDEX (g),
            .NAME_CHARS (NAME_CHARS),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_used  (r_entries_in_use),
            .i_ctl   (chain_ctl[g]),
            .i_tok   (chain_tok[g]),
            .i_mask  (chain_mask[g]),
            .i_at    (chain_at[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_tok   (chain_tok[g+1]),
            .o_mask  (chain_mask[g+1]),
            .o_at    (chain_at[g+1])
        );
    end

    // Present match results from the last cell; drop loads there
    assign last_ctl = chain_ctl[TABLE_ENTRIES];
    assign o_valid  = last_ctl.valid && (last_ctl.op == OP_MATCH);
    assign at_ext   = 32'(chain_at[TABLE_ENTRIES]);

    always_comb begin
        o_match_kind  = KIND_INVALID;
        o_exact_index = EIDX_NONE;
        if (last_ctl.tlen != '0) begin
            if (last_ctl.exact && last_ctl.prefix) begin
                o_match_kind = KIND_AMBIGUOUS;
            end else if (last_ctl.exact) begin
                o_match_kind = KIND_COMPLETE;
            end else if (last_ctl.prefix) begin
                o_match_kind = KIND_PENDING;
            end
            if (last_ctl.exact) begin
                o_exact_index = at_ext[EIDX_W-1:0];
            end
        end
    end

endmodule

[hw/rtl/pdc_cell.sv]
// One cell of the keyword chain: holds one table name and compares it with
// the item passing through. Depends on pdc_pkg.
module pdc_cell
    import pdc_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int NAME_CHARS = 8,
    parameter int IDX_W      = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [CFG_W-1:0]        i_used,
    input  t_ctl                    i_ctl,
    input  logic [NAME_CHARS*8-1:0] i_tok,
    input  logic [NAME_CHARS*8-1:0] i_mask,
    input  logic [IDX_W-1:0]        i_at,
    output t_ctl                    o_ctl,
    output logic [NAME_CHARS*8-1:0] o_tok,
    output logic [NAME_CHARS*8-1:0] o_mask,
    output logic [IDX_W-1:0]        o_at
);

    localparam int NAME_W = NAME_CHARS * 8;

    logic [NAME_W-1:0] r_name;
    logic [LEN_W-1:0]  r_len;
    t_ctl              r_ctl;
    logic [NAME_W-1:0] r_tok;
    logic [NAME_W-1:0] r_mask;
    logic [IDX_W-1:0]  r_at;

    t_ctl              n_ctl;
    logic [IDX_W-1:0]  n_at;
    logic              load_here;
    logic              in_use;
    logic              exact_hit;
    logic              prefix_hit;

    // Decode a load aimed at this cell and whether this cell takes part
    assign load_here = i_ctl.valid && (i_ctl.op == OP_LOAD)
                       && (int'(i_ctl.slot) == CELL_INDEX);
    assign in_use    = i_ctl.valid && (i_ctl.op == OP_MATCH)
                       && (int'(i_used) > CELL_INDEX);

    // Compare the stored name with the token
    assign exact_hit  = in_use && (r_len == i_ctl.tlen) && (r_name == i_tok);
    assign prefix_hit = in_use && (r_len > i_ctl.tlen) && ((r_name & i_mask) == i_tok);

    // Merge this cell's hits into the running result; later cells win the index
    always_comb begin
        n_ctl        = i_ctl;
        n_ctl.exact  = i_ctl.exact || exact_hit;
        n_ctl.prefix = i_ctl.prefix || prefix_hit;
        n_at         = exact_hit ? IDX_W'(CELL_INDEX) : i_at;
    end

    // Store a loaded name
    always_ff @(posedge i_clk) begin
        if (i_adv && load_here) begin
            r_name <= i_tok;
            r_len  <= i_ctl.tlen;
        end
    end

    // Advance the item to the next cell; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_adv) begin
            r_ctl.op     <= n_ctl.op;
            r_ctl.slot   <= n_ctl.slot;
            r_ctl.tlen   <= n_ctl.tlen;
            r_ctl.exact  <= n_ctl.exact;
            r_ctl.prefix <= n_ctl.prefix;
            r_tok        <= i_tok;
            r_mask       <= i_mask;
            r_at         <= n_at;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_tok  = r_tok;
    assign o_mask = r_mask;
    assign o_at   = r_at;

endmodule
